>>> rtl/core/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the line pixel rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int CoordW = 6;
  localparam int ColorW = 32;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [ColorW-1:0] color_t;

  // one line command beat
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } line_cmd_t;

  // one pixel beat
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } pixel_t;

endpackage

>>> rtl/core/line_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Line command in, one pixel per cycle out, minor axis interpolated exactly.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The endpoint
// differences are formed bit-serially in S_SUB, then S_ABS takes
// absolute values and S_ORDER orders the endpoints and picks the major
// axis. After that one pixel beat leaves per cycle on out_strobe, d+1 beats
// for a major-axis length d, the last one flagged by last_pixel. busy drops
// in the cycle that shows the last pixel; a new command is taken only once
// busy is low, so one line is finished before the next is taken. There is
// no output backpressure: every beat is shown for exactly one cycle and
// must be taken.
module line_pixel_rasterizer #(
  parameter int GRID_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lpr_pkg::line_cmd_t in_cmd,
  output logic              out_strobe,
  output lpr_pkg::pixel_t   out_pixel
);
  import lpr_pkg::*;

  localparam coord_t GridMax = coord_t'(GRID_SIZE - 1);
  localparam logic [2:0] LastBit = 3'(CoordW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_ABS,
    S_ORDER,
    S_RUN
  } state_t;

  state_t state_r;

  // endpoint rotators, difference shifters and borrows
  coord_t ax_r, ay_r, bx_r, by_r;
  coord_t dfx_r, dfy_r;
  logic   brx_r, bry_r;
  logic [2:0] cnt_r;
  coord_t adx_r, ady_r;
  color_t color_r;

  // stepping state
  coord_t maj_r, min0_r, d_r, delta_r, rem_r, q_r;
  logic   dec_r, swap_r;
  logic [CoordW:0] err_r;

  logic   out_strobe_r;
  pixel_t out_pixel_r;

  function automatic coord_t clamp(input coord_t c);
    clamp = (c > GridMax) ? GridMax : c;
  endfunction

  // serial subtract b - a, lsb first
  logic dx_bit, dy_bit, brx_nxt, bry_nxt;
  always_comb begin
    dx_bit  = bx_r[0] ^ ax_r[0] ^ brx_r;
    dy_bit  = by_r[0] ^ ay_r[0] ^ bry_r;
    brx_nxt = (~bx_r[0] & ax_r[0]) | (~(bx_r[0] ^ ax_r[0]) & brx_r);
    bry_nxt = (~by_r[0] & ay_r[0]) | (~(by_r[0] ^ ay_r[0]) & bry_r);
  end

  // axis choice and endpoint ordering
  logic   swap_c, flip_c;
  coord_t maj0_c, min0_c, d_c, delta_c;
  logic   dec_c;
  always_comb begin
    swap_c = adx_r < ady_r;
    if (swap_c) begin
      flip_c  = bry_r;
      maj0_c  = flip_c ? by_r : ay_r;
      min0_c  = flip_c ? bx_r : ax_r;
      d_c     = ady_r;
      delta_c = adx_r;
      dec_c   = brx_r ^ flip_c;
    end else begin
      flip_c  = brx_r;
      maj0_c  = flip_c ? bx_r : ax_r;
      min0_c  = flip_c ? by_r : ay_r;
      d_c     = adx_r;
      delta_c = ady_r;
      dec_c   = bry_r ^ flip_c;
    end
  end

  // minor-axis error step and pixel forming
  logic [CoordW:0] sum_c, err_nxt;
  logic   wrap_c;
  coord_t mnr_c;
  pixel_t pix_c;
  always_comb begin
    sum_c   = err_r + {1'b0, delta_r};
    wrap_c  = sum_c >= {1'b0, d_r};
    err_nxt = wrap_c ? (sum_c - {1'b0, d_r}) : sum_c;
    mnr_c   = dec_r ? (min0_r - q_r) : (min0_r + q_r);
    pix_c.pixel_x     = swap_r ? mnr_c : maj_r;
    pix_c.pixel_y     = swap_r ? maj_r : mnr_c;
    pix_c.pixel_color = color_r;
    pix_c.last_pixel  = (rem_r == '0);
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            ax_r    <= clamp(in_cmd.start_x);
            ay_r    <= clamp(in_cmd.start_y);
            bx_r    <= clamp(in_cmd.end_x);
            by_r    <= clamp(in_cmd.end_y);
            color_r <= in_cmd.line_color;
            brx_r   <= 1'b0;
            bry_r   <= 1'b0;
            cnt_r   <= '0;
            state_r <= S_SUB;
          end
        end
        S_SUB: begin
          ax_r  <= {ax_r[0], ax_r[CoordW-1:1]};
          ay_r  <= {ay_r[0], ay_r[CoordW-1:1]};
          bx_r  <= {bx_r[0], bx_r[CoordW-1:1]};
          by_r  <= {by_r[0], by_r[CoordW-1:1]};
          dfx_r <= {dx_bit, dfx_r[CoordW-1:1]};
          dfy_r <= {dy_bit, dfy_r[CoordW-1:1]};
          brx_r <= brx_nxt;
          bry_r <= bry_nxt;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == LastBit) begin
            state_r <= S_ABS;
          end
        end
        S_ABS: begin
          adx_r   <= brx_r ? (~dfx_r + coord_t'(1)) : dfx_r;
          ady_r   <= bry_r ? (~dfy_r + coord_t'(1)) : dfy_r;
          state_r <= S_ORDER;
        end
        S_ORDER: begin
          swap_r  <= swap_c;
          maj_r   <= maj0_c;
          min0_r  <= min0_c;
          d_r     <= d_c;
          delta_r <= delta_c;
          dec_r   <= dec_c;
          rem_r   <= d_c;
          q_r     <= '0;
          err_r   <= dec_c ? {1'b0, d_c - coord_t'(1)} : '0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          out_strobe_r <= 1'b1;
          out_pixel_r  <= pix_c;
          maj_r        <= maj_r + coord_t'(1);
          rem_r        <= rem_r - coord_t'(1);
          err_r        <= err_nxt;
          q_r          <= q_r + coord_t'(wrap_c);
          if (rem_r == '0) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_pixel  = out_pixel_r;

  // checks
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pixel.last_pixel) |-> !busy)
    else $error("busy still high with last pixel");

  a_beat_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("pixel beat without command in flight");

  a_take_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_beats_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_pixel.last_pixel) |=> out_strobe)
    else $error("gap inside a line");

  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && d_r != '0) |-> (err_r < {1'b0, d_r}))
    else $error("minor error term out of range");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line pixel rasterizer. Line commands are driven
// from a queue at the falling edge. Each accepted command is expanded into its
// expected pixel beats by a local line predictor. Pixel beats are checked
// field by field, in order, at the rising edge.
// ----------------------------------------------------------------------------
module tb_top;

  import lpr_pkg::*;

  localparam int GridMax    = 63;
  localparam int RandomN    = 270;
  localparam int TailCycles = 80;
  localparam int CycleLimit = 200000;

  logic      clk    = 1'b0;
  logic      rst_n  = 1'b0;
  logic      start  = 1'b0;
  line_cmd_t in_cmd = '0;
  logic      busy;
  logic      out_strobe;
  pixel_t    out_pixel;

  line_cmd_t cmd_q[$];
  pixel_t    pixel_q[$];
  bit        cmd_taken = 1'b0;
  int        sent      = 0;
  int        cmd_total = 0;
  int        directed_n = 0;
  int        errors    = 0;
  int        cycles    = 0;

  line_pixel_rasterizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .out_strobe(out_strobe),
    .out_pixel (out_pixel)
  );

  always #5 clk = ~clk;

  // expand one line command into the pixel beats it must produce
  function automatic void rasterize_line(line_cmd_t c);
    int ax, ay, bx, by;
    int maj0, min0, maj1, min1, t, d, mnr;
    bit steep;
    pixel_t p;
    // 6-bit coordinates already sit inside a 64-wide grid, so no clamping
    ax = c.start_x;
    ay = c.start_y;
    bx = c.end_x;
    by = c.end_y;
    steep = ((ax > bx) ? ax - bx : bx - ax) < ((ay > by) ? ay - by : by - ay);
    if (steep) begin
      maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
    end else begin
      maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
    end
    // walk the major axis upward
    if (maj0 > maj1) begin
      t = maj0; maj0 = maj1; maj1 = t;
      t = min0; min0 = min1; min1 = t;
    end
    d = maj1 - maj0;
    for (int k = 0; k <= d; k++) begin
      mnr = (d == 0) ? min0 : (min0 * (d - k) + min1 * k) / d;
      if (steep) begin
        p.pixel_x = coord_t'(mnr);
        p.pixel_y = coord_t'(maj0 + k);
      end else begin
        p.pixel_x = coord_t'(maj0 + k);
        p.pixel_y = coord_t'(mnr);
      end
      p.pixel_color = c.line_color;
      p.last_pixel  = (k == d);
      pixel_q.push_back(p);
    end
  endfunction

  function automatic void add_line(int x0, int y0, int x1, int y1, color_t col);
    line_cmd_t c;
    c.start_x    = coord_t'(x0);
    c.start_y    = coord_t'(y0);
    c.end_x      = coord_t'(x1);
    c.end_y      = coord_t'(y1);
    c.line_color = col;
    cmd_q.push_back(c);
  endfunction

  // command driver, changes inputs on the falling edge
  always @(negedge clk) begin : drive
    int idle_pct;
    idle_pct = (sent < cmd_total / 3) ? 36 : (sent < 2 * cmd_total / 3) ? 78 : 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !cmd_taken) begin
      // beat still waiting for the block
    end else if (cmd_q.size() != 0 &&
                 !((sent == directed_n || sent == cmd_total / 2) && pixel_q.size() != 0) &&
                 $urandom_range(99) >= idle_pct) begin
      in_cmd <= cmd_q.pop_front();
      start  <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // accept commands and check pixel beats on the rising edge
  always @(posedge clk) begin : watch
    pixel_t want;
    cmd_taken = rst_n && start && !busy;
    if (cmd_taken) begin
      rasterize_line(in_cmd);
      sent++;
    end
    if (rst_n && out_strobe) begin
      if (pixel_q.size() == 0) begin
        $error("pixel beat with none expected: x=%0d y=%0d", out_pixel.pixel_x,
               out_pixel.pixel_y);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (out_pixel.pixel_x !== want.pixel_x) begin
          $error("pixel_x expected %0d got %0d", want.pixel_x, out_pixel.pixel_x);
          errors++;
        end
        if (out_pixel.pixel_y !== want.pixel_y) begin
          $error("pixel_y expected %0d got %0d", want.pixel_y, out_pixel.pixel_y);
          errors++;
        end
        if (out_pixel.pixel_color !== want.pixel_color) begin
          $error("pixel_color expected %h got %h", want.pixel_color,
                 out_pixel.pixel_color);
          errors++;
        end
        if (out_pixel.last_pixel !== want.last_pixel) begin
          $error("last_pixel expected %0d got %0d", want.last_pixel,
                 out_pixel.last_pixel);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stim
    int x0, y0, x1, y1, len;
    // zero-length lines at both grid corners
    add_line(0, 0, 0, 0, 32'h0000_0000);
    add_line(GridMax, GridMax, GridMax, GridMax, 32'hFFFF_FFFF);
    // full-width horizontal and full-height vertical, both directions
    add_line(0, 0, GridMax, 0, 32'hA5A5_A5A5);
    add_line(GridMax, GridMax, 0, GridMax, 32'h5A5A_5A5A);
    add_line(0, 0, 0, GridMax, 32'hFFFF_FFFF);
    add_line(GridMax, GridMax, GridMax, 0, 32'h0000_0000);
    // equal |dx| and |dy| keeps x as the major axis
    add_line(0, 0, GridMax, GridMax, 32'h1234_5678);
    add_line(GridMax, 0, 0, GridMax, 32'h8765_4321);
    add_line(10, 20, 5, 15, 32'hDEAD_BEEF);
    // shallow and steep, endpoints in either order
    add_line(0, 0, GridMax, 1, 32'hFF00_FF00);
    add_line(GridMax, 1, 0, 0, 32'h00FF_00FF);
    add_line(0, 0, 1, GridMax, 32'hF0F0_F0F0);
    add_line(1, GridMax, 0, 0, 32'h0F0F_0F0F);
    add_line(3, 60, 50, 2, 32'hCAFE_F00D);
    add_line(40, 7, 9, 62, 32'h8000_0001);
    // single-step lines
    add_line(5, 5, 6, 5, 32'h7FFF_FFFE);
    add_line(5, 5, 5, 6, 32'hFFFF_0000);
    add_line(30, 30, 31, 31, 32'h0000_FFFF);
    directed_n = cmd_q.size();

    for (int i = 0; i < RandomN; i++) begin
      case ($urandom_range(3))
        0: begin
          // short line around a random point, sometimes a single point
          x0 = $urandom_range(GridMax);
          y0 = $urandom_range(GridMax);
          x1 = x0 + $urandom_range(8) - 4;
          y1 = y0 + $urandom_range(8) - 4;
          x1 = (x1 < 0) ? 0 : (x1 > GridMax) ? GridMax : x1;
          y1 = (y1 < 0) ? 0 : (y1 > GridMax) ? GridMax : y1;
        end
        1: begin
          // exact diagonal, then mirrored or reversed
          len = $urandom_range(GridMax);
          x0 = $urandom_range(GridMax - len);
          y0 = $urandom_range(GridMax - len);
          x1 = x0 + len;
          y1 = y0 + len;
          if ($urandom_range(1)) begin
            y0 = GridMax - y0;
            y1 = GridMax - y1;
          end
          if ($urandom_range(1)) begin
            len = x0; x0 = x1; x1 = len;
            len = y0; y0 = y1; y1 = len;
          end
        end
        2: begin
          // axis aligned
          x0 = $urandom_range(GridMax);
          y0 = $urandom_range(GridMax);
          x1 = $urandom_range(1) ? $urandom_range(GridMax) : x0;
          y1 = (x1 == x0) ? $urandom_range(GridMax) : y0;
        end
        default: begin
          x0 = $urandom_range(GridMax);
          y0 = $urandom_range(GridMax);
          x1 = $urandom_range(GridMax);
          y1 = $urandom_range(GridMax);
        end
      endcase
      add_line(x0, y0, x1, y1, $urandom());
    end
    cmd_total = cmd_q.size();

    // reset held low, then released at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // drain everything, then watch for stray beats
    while (cmd_q.size() != 0 || start || pixel_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (errors == 0 && pixel_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
